// ===== rtl/dxmt_pkg.sv =====
// dxmt_pkg: shared types, request codes and size constants for the id/mac table
// no dependencies
`default_nettype none
package dxmt_pkg;
  localparam int DefEntries = 16;
  localparam int MaxEntries = 64;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_AGE    = 3'd2;
  localparam logic [2:0] REQ_TICK   = 3'd3;
  localparam logic [2:0] REQ_SNAP   = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] xid;
    logic [47:0] client_mac;
    logic [6:0]  max_count;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [31:0] id_out;
    logic [47:0] mac_out;
    logic signed [31:0] ttl_left;
    logic        last;
  } out_res_t;

  // one table entry as it moves along the cell row
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [47:0] mac;
    logic [31:0] expiry;
  } entry_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic        shift;  // rotate the ring one position
    logic        wr;     // overwrite the head entry
    entry_t      wr_ent;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/dhcp_xid_mac_ttl_table_top.sv =====
// dhcp_xid_mac_ttl_table_top: id to mac table with tick-based expiry
// depends on dxmt_pkg, dxmt_seq, dxmt_ring, dxmt_cell
//
// channel   ports                          handshake
// in        in_req                         start & !busy
// out       out_res                        out_valid, one cycle, no stall
// cfg       cfg_we, cfg_wdata (ttl_ticks)  cfg_we
//
// every request walks the ring of ENTRIES cells once; an insert that places a
// new entry adds a second full pass that writes the chosen slot on the way.
// each snapshot result is held until the next reported cell is found and then
// leaves as a register output; the final one leaves after the pass, in the
// first idle cycle. a new request is taken only when the last has ended.
// synchronous active-low reset clears the table and time and sets ttl to 60.
// the receiver cannot stall; results are shown for exactly one cycle.
`default_nettype none
module dhcp_xid_mac_ttl_table_top #(
  parameter int ENTRIES = dxmt_pkg::DefEntries
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  dxmt_pkg::in_req_t   in_req,
  input  wire                 cfg_we,
  input  wire [15:0]          cfg_wdata,
  output logic                out_valid,
  output dxmt_pkg::out_res_t  out_res
);
  import dxmt_pkg::*;
  cell_ctl_t ctl;
  entry_t    head;

  dxmt_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .head(head), .ctl(ctl),
    .out_valid(out_valid), .out_res(out_res)
  );

  dxmt_ring #(.ENTRIES(ENTRIES)) u_ring (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .head(head)
  );

  // a result other than the last is shown only while a request is in progress
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |-> busy) else $error("early result outside request");
  // the last result is shown once the request has ended
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |-> !busy) else $error("busy with last result");
  // a request is accepted only when idle and leads to busy
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
endmodule
`default_nettype wire

// ===== rtl/dxmt_cell.sv =====
// dxmt_cell: one storage cell of the rotating entry ring
// depends on dxmt_pkg
`default_nettype none
module dxmt_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dxmt_pkg::cell_ctl_t  ctl,
  input  wire                  is_head,
  input  wire                  is_tail,
  input  dxmt_pkg::entry_t     prev_ent,
  output dxmt_pkg::entry_t     ent
);
  import dxmt_pkg::*;
  entry_t ent_r, ent_nxt;

  // take the neighbor's entry on a shift; the head entry may be overwritten,
  // in the tail cell when it moves there on a shift, else in the head cell
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) ent_nxt = prev_ent;
    if (ctl.wr && (ctl.shift ? is_tail : is_head)) ent_nxt = ctl.wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

// ===== rtl/dxmt_ring.sv =====
// dxmt_ring: row of cells closed into a ring; cell 0 is the head
// depends on dxmt_pkg, dxmt_cell
`default_nettype none
module dxmt_ring #(
  parameter int ENTRIES = dxmt_pkg::DefEntries
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dxmt_pkg::cell_ctl_t  ctl,
  output dxmt_pkg::entry_t     head
);
  import dxmt_pkg::*;
  entry_t ents [ENTRIES];

  // cell k takes from cell k+1, so the head walks up the slot index
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    dxmt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .is_head  (k == 0),
      .is_tail  (k == ENTRIES - 1),
      .prev_ent (ents[(k + 1) % ENTRIES]),
      .ent      (ents[k])
    );
  end

  assign head = ents[0];
endmodule
`default_nettype wire

// ===== rtl/dxmt_seq.sv =====
// dxmt_seq: request sequencer, walks the ring once per request, twice for an insert that places a new entry
// depends on dxmt_pkg
`default_nettype none
module dxmt_seq #(
  parameter int ENTRIES = dxmt_pkg::DefEntries
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  dxmt_pkg::in_req_t    in_req,
  input  wire                  cfg_we,
  input  wire [15:0]           cfg_wdata,
  input  dxmt_pkg::entry_t     head,
  output dxmt_pkg::cell_ctl_t  ctl,
  output logic                 out_valid,
  output dxmt_pkg::out_res_t   out_res
);
  import dxmt_pkg::*;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  st_r, st_nxt;
  in_req_t     req_r;
  logic [CW-1:0] pos_r;       // slot at the head, counts the pass
  logic [CW-1:0] tgt_r;       // slot to write after the pass
  logic [31:0] now_r;
  logic [15:0] ttl_r;
  logic        hit_r, free_ok_r;
  logic [IW-1:0] free_r, best_r;
  logic [31:0] best_exp_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] lim;
  logic        pend_r;
  out_res_t    pend_res_r;
  out_res_t    res_r;
  logic        res_v_r;
  logic [IW-1:0] pos_i;
  logic [32:0] exp_sum;
  logic [31:0] exp_new;
  logic        expired, match;
  logic [32:0] diff;
  logic signed [31:0] ttl_sat;

  assign pos_i = pos_r[IW-1:0];
  assign exp_sum = {1'b0, now_r} + {17'b0, ttl_r};
  assign exp_new = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
  assign expired = head.expiry <= now_r;
  assign match   = head.valid && head.id == req_r.xid;
  assign lim = (req_r.max_count > 7'(ENTRIES)) ? CW'(ENTRIES) : CW'(req_r.max_count);
  assign diff = {1'b0, head.expiry} - {1'b0, now_r};
  // difference is at least -(2^32-1); clip to [-2^31, 65535]
  always_comb begin
    if (!diff[32]) ttl_sat = (diff[31:16] != 16'd0) ? 32'sd65535 : 32'(diff[15:0]);
    else if (!diff[31]) ttl_sat = 32'h8000_0000;
    else ttl_sat = diff[31:0];
  end

  assign busy = (st_r != ST_IDLE);

  // ring control: rotate; scan updates or ages the head; fix pass writes target
  always_comb begin
    ctl = '0;
    ctl.wr_ent = '{valid: 1'b1, id: req_r.xid, mac: req_r.client_mac, expiry: exp_new};
    if (st_r == ST_SCAN) begin
      ctl.shift = 1'b1;
      if (req_r.req_type == REQ_INSERT && match && !hit_r) ctl.wr = 1'b1;
      if (req_r.req_type == REQ_AGE && head.valid && expired) begin
        ctl.wr = 1'b1;
        ctl.wr_ent = head;
        ctl.wr_ent.valid = 1'b0;
      end
    end else if (st_r == ST_FIX) begin
      ctl.shift = 1'b1;
      if (pos_r == tgt_r) ctl.wr = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start) st_nxt = ST_SCAN;
      ST_SCAN: if (pos_r == CW'(ENTRIES - 1))
                 st_nxt = (req_r.req_type == REQ_INSERT && !hit_r && !match) ? ST_FIX : ST_DONE;
      ST_FIX:  if (pos_r == CW'(ENTRIES - 1)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      now_r <= '0;
      ttl_r <= 16'd60;
      res_v_r <= 1'b0;
      pend_r <= 1'b0;
      pos_r <= '0;
    end else begin
      st_r <= st_nxt;
      res_v_r <= 1'b0;
      if (cfg_we) ttl_r <= cfg_wdata;
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            req_r <= in_req;
            pos_r <= '0;
            hit_r <= 1'b0;
            free_ok_r <= 1'b0;
            free_r <= '0;
            best_r <= '0;
            best_exp_r <= head.expiry;
            cnt_r <= '0;
            pend_r <= 1'b0;
            pend_res_r <= '0;
          end
        end
        ST_SCAN: begin
          pos_r <= (pos_r == CW'(ENTRIES - 1)) ? '0 : pos_r + 1'b1;
          case (req_r.req_type)
            REQ_INSERT: begin
              if (!hit_r) begin
                if (match) begin
                  hit_r <= 1'b1;
                  pend_res_r <= '0;
                  pend_res_r.found <= 1'b1;
                  pend_res_r.slot <= 6'(pos_i);
                  pend_res_r.id_out <= req_r.xid;
                end else begin
                  if ((!head.valid || expired) && !free_ok_r) begin
                    free_ok_r <= 1'b1;
                    free_r <= pos_i;
                  end
                  if (head.expiry < best_exp_r) begin
                    best_exp_r <= head.expiry;
                    best_r <= pos_i;
                  end
                end
              end
            end
            REQ_LOOKUP: begin
              if (!hit_r && match && !expired) begin
                hit_r <= 1'b1;
                pend_res_r.found <= 1'b1;
                pend_res_r.slot <= 6'(pos_i);
                pend_res_r.id_out <= head.id;
                pend_res_r.mac_out <= head.mac;
              end
            end
            REQ_SNAP: begin
              if (head.valid && cnt_r < lim) begin
                cnt_r <= cnt_r + 1'b1;
                if (pend_r) begin
                  res_r <= pend_res_r;
                  res_v_r <= 1'b1;
                end
                pend_r <= 1'b1;
                pend_res_r <= '{found: 1'b1, slot: 6'(pos_i), id_out: head.id,
                                mac_out: head.mac, ttl_left: ttl_sat, last: 1'b0};
              end
            end
            REQ_TICK: begin
              if (pos_r == '0 && now_r != 32'hFFFF_FFFF) now_r <= now_r + 1'b1;
            end
            default: ;
          endcase
          if (pos_r == CW'(ENTRIES - 1) && req_r.req_type == REQ_INSERT && !hit_r
              && !match) begin
            tgt_r <= CW'((free_ok_r || !(head.valid && !expired)) ?
                         (free_ok_r ? free_r : pos_i) :
                         ((head.expiry < best_exp_r) ? pos_i : best_r));
          end
        end
        ST_FIX: begin
          pos_r <= (pos_r == CW'(ENTRIES - 1)) ? '0 : pos_r + 1'b1;
          if (pos_r == tgt_r) begin
            pend_res_r <= '0;
            pend_res_r.slot <= 6'(pos_i);
            pend_res_r.id_out <= req_r.xid;
          end
        end
        ST_DONE: begin
          res_v_r <= 1'b1;
          res_r <= pend_res_r;
          res_r.last <= 1'b1;
          pend_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = res_v_r;
  assign out_res = res_r;
endmodule
`default_nettype wire
